@@ hw/rtl/pctc_pkg.sv @@
// ----------------------------------------------------------------------------
// pctc_pkg: shared types and constants
// Field widths, mode and matrix codes, and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pctc_pkg;

  localparam int VC_W   = 5;
  localparam int ROW_W  = 16;
  localparam int RIDX_W = 4;
  localparam int CNT_W  = 5;
  localparam int HIST_W = 6;

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_CMP   = 1'b1;
  localparam logic MAT_FIRST  = 1'b0;
  localparam logic MAT_SECOND = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic chk;
    logic chk_done;
    logic rewind;
    logic walk;
    logic capture;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic walk_end;
  } sts_t;

  function automatic logic [RIDX_W-1:0] low_bit_index(input logic [ROW_W-1:0] v);
    logic [RIDX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) idx = RIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/pctc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pctc_ctrl: compare sequencer
// Accepts row loads and compare requests, steps the datapath through the
// well-formedness scan and the cycle walk of each matrix, and owns out_valid.
// ----------------------------------------------------------------------------
module pctc_ctrl
  import pctc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_WLK  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   mat_r, mat_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.sel   = mat_r;
    state_nxt = state_r;
    mat_nxt   = mat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_CMP) begin
            cmd.clear = 1'b1;
            mat_nxt   = MAT_FIRST;
            state_nxt = S_CHK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (sts.scan_end) begin
          cmd.rewind   = 1'b1;
          cmd.chk_done = 1'b1;
          if (mat_r == MAT_FIRST) begin
            mat_nxt = MAT_SECOND;
          end else begin
            mat_nxt   = MAT_FIRST;
            state_nxt = S_WLK;
          end
        end else begin
          cmd.chk = 1'b1;
        end
      end
      S_WLK: begin
        if (sts.walk_end) begin
          if (mat_r == MAT_FIRST) begin
            cmd.rewind = 1'b1;
            mat_nxt    = MAT_SECOND;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.capture | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mat_r       <= MAT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mat_r       <= mat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cmp_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == MODE_CMP) |=> (state_r == S_CHK))
    else $error("compare beat did not start the scan");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_ready))
    else $error("result captured over a pending beat");

  a_walk_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WLK && sts.walk_end && mat_r == MAT_SECOND) |=> (state_r == S_FIN))
    else $error("second walk end did not finish the compare");

endmodule

@@ hw/rtl/pctc_dp.sv @@
// ----------------------------------------------------------------------------
// pctc_dp: row store, permutation check and cycle walk datapath
// Holds both matrices and the vertex count, checks one row per step, follows
// one edge per step, and keeps a difference histogram of cycle lengths.
// ----------------------------------------------------------------------------
module pctc_dp
  import pctc_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [VC_W-1:0]    cfg_wr_data,
  input  logic               in_matrix_select,
  input  logic [RIDX_W-1:0]  in_row_index,
  input  logic [ROW_W-1:0]   in_row_bits,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_isomorphic,
  output logic               out_malformed,
  output logic [CNT_W-1:0]   out_cycles_first,
  output logic [CNT_W-1:0]   out_cycles_second
);

  localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int IDXW = $clog2(ROWS);
  localparam int NW   = IDXW + 1;

  logic [VC_W-1:0]          vc_r;
  logic [ROW_W-1:0]         mem_r [2][ROWS];
  logic [NW-1:0]            r_r;
  logic [ROW_W-1:0]         cols_r;
  logic [1:0]               ok_r;
  logic [ROWS-1:0]          vis_r;
  logic [IDXW-1:0]          cur_r;
  logic [IDXW-1:0]          start_r;
  logic [IDXW-1:0]          len_r;
  logic                     incyc_r;
  logic signed [HIST_W-1:0] hist_r [ROWS];
  logic [NW-1:0]            nz_r;
  logic [CNT_W-1:0]         cnt_r [2];

  logic [NW-1:0]            n;
  logic [ROW_W-1:0]         mask;
  logic [IDXW-1:0]          v_addr;
  logic [ROW_W-1:0]         row;
  logic                     row_one;
  logic [RIDX_W-1:0]        low_idx;
  logic [IDXW-1:0]          nxt;
  logic [IDXW-1:0]          st;
  logic [IDXW-1:0]          ln;
  logic                     skip;
  logic                     close;
  logic signed [HIST_W-1:0] hist_old;
  logic signed [HIST_W-1:0] hist_new;

  always_comb begin
    if (vc_r > VC_W'(ROWS)) n = NW'(ROWS);
    else                    n = vc_r[NW-1:0];
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = (VC_W'(j) < VC_W'(n));
    end
  end

  assign v_addr   = incyc_r ? cur_r : r_r[IDXW-1:0];
  assign row      = mem_r[cmd.sel][v_addr] & mask;
  assign row_one  = (row != '0) && ((row & (row - 16'd1)) == '0);
  assign low_idx  = low_bit_index(row);
  assign nxt      = low_idx[IDXW-1:0];
  assign st       = incyc_r ? start_r : r_r[IDXW-1:0];
  assign ln       = incyc_r ? len_r : '0;
  assign skip     = !incyc_r && vis_r[r_r[IDXW-1:0]];
  assign close    = (nxt == st);
  assign hist_old = hist_r[ln];
  assign hist_new = (cmd.sel == MAT_SECOND) ? hist_old - 6'sd1 : hist_old + 6'sd1;

  assign sts.scan_end = (r_r == n);
  assign sts.walk_end = (r_r == n) || !ok_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_wr_en) begin
      vc_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, in_row_index} < VC_W'(ROWS))) begin
      mem_r[in_matrix_select][in_row_index[IDXW-1:0]] <= in_row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      r_r     <= '0;
      cols_r  <= '0;
      ok_r    <= 2'b11;
      vis_r   <= '0;
      cur_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      incyc_r <= 1'b0;
      nz_r    <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      for (int i = 0; i < ROWS; i++) hist_r[i] <= '0;
    end else if (cmd.rewind) begin
      r_r     <= '0;
      cols_r  <= '0;
      vis_r   <= '0;
      incyc_r <= 1'b0;
      if (cmd.chk_done && cols_r != mask) ok_r[cmd.sel] <= 1'b0;
    end else if (cmd.chk) begin
      if (!row_one || (cols_r & row) != '0) ok_r[cmd.sel] <= 1'b0;
      cols_r <= cols_r | row;
      r_r    <= r_r + 1'b1;
    end else if (cmd.walk) begin
      if (skip) begin
        r_r <= r_r + 1'b1;
      end else begin
        vis_r[v_addr] <= 1'b1;
        if (close) begin
          // cycle closed: log its length
          hist_r[ln] <= hist_new;
          if (hist_old == '0)      nz_r <= nz_r + 1'b1;
          else if (hist_new == '0) nz_r <= nz_r - 1'b1;
          cnt_r[cmd.sel] <= cnt_r[cmd.sel] + 1'b1;
          incyc_r <= 1'b0;
          r_r     <= r_r + 1'b1;
        end else begin
          cur_r   <= nxt;
          start_r <= st;
          len_r   <= ln + 1'b1;
          incyc_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_isomorphic    <= ok_r[0] && ok_r[1] && (nz_r == '0);
      out_malformed     <= !(ok_r[0] && ok_r[1]);
      out_cycles_first  <= cnt_r[0];
      out_cycles_second <= cnt_r[1];
    end
  end

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (nz_r == '0 && ok_r == 2'b11))
    else $error("compare start left stale state");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && incyc_r) |-> ({1'b0, cur_r} < n))
    else $error("walk left the active vertex range");

  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.capture) |-> !(out_isomorphic && out_malformed))
    else $error("isomorphic reported on a malformed matrix");

endmodule

@@ hw/rtl/permutation_cycle_type_compare.sv @@
// ----------------------------------------------------------------------------
// permutation_cycle_type_compare: compares the cycle types of two matrices
// Row loads are accepted one beat per cycle while no compare is in progress. A
// compare beat scans every active row of each matrix, then walks each well-formed
// matrix, stepping once per vertex plus once per already visited row. Synchronous
// active-low reset clears control state and sets vertex_count to 16; stored rows
// are undefined until loaded.
// ----------------------------------------------------------------------------
module permutation_cycle_type_compare
  import pctc_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [VC_W-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic              in_matrix_select,
  input  logic [RIDX_W-1:0] in_row_index,
  input  logic [ROW_W-1:0]  in_row_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_isomorphic,
  output logic              out_malformed,
  output logic [CNT_W-1:0]  out_cycles_first,
  output logic [CNT_W-1:0]  out_cycles_second
);

  cmd_t cmd;
  sts_t sts;

  pctc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pctc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_matrix_select  (in_matrix_select),
    .in_row_index      (in_row_index),
    .in_row_bits       (in_row_bits),
    .cmd               (cmd),
    .sts               (sts),
    .out_isomorphic    (out_isomorphic),
    .out_malformed     (out_malformed),
    .out_cycles_first  (out_cycles_first),
    .out_cycles_second (out_cycles_second)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for permutation_cycle_type_compare
// Loads pairs of matrices one row per beat and sends compare beats. Each
// accepted compare is predicted from a local copy of the row store and the
// vertex count, and each result beat is checked field by field. Sender and
// receiver idle at random, and one long receiver stall fills the block.
// ----------------------------------------------------------------------------
module tb;
  import pctc_pkg::*;

  localparam int MAX_V        = 16;
  localparam int DRAIN_CYCLES = 120;
  localparam int QUIET_LIMIT  = 3000;
  localparam int ITEM_TARGET  = 1100;

  typedef struct packed {
    logic             iso;
    logic             malformed;
    logic [CNT_W-1:0] cycles_first;
    logic [CNT_W-1:0] cycles_second;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [VC_W-1:0]   cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_mode;
  logic              in_matrix_select;
  logic [RIDX_W-1:0] in_row_index;
  logic [ROW_W-1:0]  in_row_bits;
  logic              out_valid;
  logic              out_ready;
  logic              out_isomorphic;
  logic              out_malformed;
  logic [CNT_W-1:0]  out_cycles_first;
  logic [CNT_W-1:0]  out_cycles_second;

  logic [ROW_W-1:0] row_store [2][MAX_V];
  logic [VC_W-1:0]  vertex_limit;
  verdict_t         verdict_q [$];
  int               mismatch_count = 0;
  int               accepted_items = 0;
  int               hold_request = 0;
  int               quiet_cycles = 0;
  bit               idling_on = 1'b1;

  permutation_cycle_type_compare #(
    .MAX_VERTICES(MAX_V)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_matrix_select (in_matrix_select),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_isomorphic   (out_isomorphic),
    .out_malformed    (out_malformed),
    .out_cycles_first (out_cycles_first),
    .out_cycles_second(out_cycles_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ROW_W-1:0] active_mask(input int n);
    return (n >= ROW_W) ? '1 : ROW_W'((1 << n) - 1);
  endfunction

  function automatic verdict_t predict_verdict();
    int               n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] v;
    logic [ROW_W-1:0] cols;
    logic [ROW_W-1:0] seen;
    logic             ok [2];
    int               lens [2][MAX_V + 1];
    int               count [2];
    int               nxt [MAX_V];
    int               len;
    int               cur;
    verdict_t         res;
    n = (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
    mask = active_mask(n);
    for (int m = 0; m < 2; m++) begin
      ok[m] = 1'b1;
      cols = '0;
      count[m] = 0;
      for (int h = 0; h <= MAX_V; h++) lens[m][h] = 0;
      for (int r = 0; r < n; r++) begin
        v = row_store[m][r] & mask;
        if (v == '0 || (v & (v - 1'b1)) != '0 || (cols & v) != '0) ok[m] = 1'b0;
        cols = cols | v;
        nxt[r] = 0;
        for (int j = ROW_W - 1; j >= 0; j--) if (v[j]) nxt[r] = j;
      end
      if (cols != mask) ok[m] = 1'b0;
      if (ok[m]) begin
        seen = '0;
        for (int r = 0; r < n; r++) begin
          if (!seen[r]) begin
            len = 0;
            cur = r;
            do begin
              seen[cur] = 1'b1;
              len++;
              cur = nxt[cur];
            end while (cur != r);
            lens[m][len]++;
            count[m]++;
          end
        end
      end
    end
    res.iso = ok[0] && ok[1];
    for (int h = 0; h <= MAX_V; h++) if (lens[0][h] != lens[1][h]) res.iso = 1'b0;
    res.malformed = !(ok[0] && ok[1]);
    res.cycles_first = CNT_W'(count[0]);
    res.cycles_second = CNT_W'(count[1]);
    return res;
  endfunction

  function automatic void shuffle_perm(output int p [MAX_V], input int n);
    int j;
    int t;
    for (int i = 0; i < MAX_V; i++) p[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
  endfunction

  // relabel vertices: same cycle type, different matrix
  function automatic void conjugate_perm(input int pa [MAX_V], output int pb [MAX_V],
                                         input int n);
    int sigma [MAX_V];
    shuffle_perm(sigma, n);
    for (int i = 0; i < MAX_V; i++) pb[i] = i;
    for (int i = 0; i < n; i++) pb[sigma[i]] = sigma[pa[i]];
  endfunction

  task automatic send_beat(input logic mode, input logic sel, input logic [RIDX_W-1:0] idx,
                           input logic [ROW_W-1:0] bits);
    int gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_matrix_select <= sel;
    in_row_index <= idx;
    in_row_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_items++;
    if (mode == MODE_LOAD) row_store[sel][idx] = bits;
    else verdict_q = {verdict_q, predict_verdict()};
  endtask

  task automatic send_compare();
    send_beat(MODE_CMP, 1'($urandom), RIDX_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [VC_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vertex_limit = value;
  endtask

  task automatic load_pair(input int pa [MAX_V], input int pb [MAX_V], input int n);
    logic [ROW_W-1:0] mask;
    mask = active_mask(n);
    for (int r = 0; r < n; r++) begin
      send_beat(MODE_LOAD, MAT_FIRST, RIDX_W'(r),
                (ROW_W'(1) << pa[r]) | (ROW_W'($urandom) & ~mask));
      send_beat(MODE_LOAD, MAT_SECOND, RIDX_W'(r),
                (ROW_W'(1) << pb[r]) | (ROW_W'($urandom) & ~mask));
    end
  endtask

  task automatic run_sequence(input int n, input int kind);
    int               pa [MAX_V];
    int               pb [MAX_V];
    int               m;
    int               r;
    logic [ROW_W-1:0] bits;
    if (kind == 9) begin
      repeat ($urandom_range(1, 4))
        send_beat(MODE_LOAD, 1'($urandom), RIDX_W'($urandom), ROW_W'($urandom));
      send_compare();
      return;
    end
    shuffle_perm(pa, n);
    if (kind < 6 || kind == 8) conjugate_perm(pa, pb, n);
    else shuffle_perm(pb, n);
    load_pair(pa, pb, n);
    if (n < MAX_V && $urandom_range(0, 3) == 0)
      send_beat(MODE_LOAD, 1'($urandom), RIDX_W'($urandom_range(n, MAX_V - 1)),
                ROW_W'($urandom));
    if (kind == 8 && n > 0) begin
      m = $urandom_range(0, 1);
      r = $urandom_range(0, n - 1);
      case ($urandom_range(0, 2))
        0: bits = '0;
        1: bits = row_store[m][r] | (ROW_W'(1) << $urandom_range(0, n - 1));
        default: bits = row_store[m][$urandom_range(0, n - 1)];
      endcase
      send_beat(MODE_LOAD, 1'(m), RIDX_W'(r), bits);
    end
    send_compare();
  endtask

  task automatic test_full_width();
    int pa [MAX_V];
    int pb [MAX_V];
    for (int r = 0; r < MAX_V; r++) begin
      pa[r] = (r + 1) % MAX_V;
      pb[r] = (r + MAX_V - 1) % MAX_V;
    end
    load_pair(pa, pb, MAX_V);
    send_compare();
    set_vertex_count(5'd31);
    send_compare();
    set_vertex_count(5'd17);
    send_compare();
  endtask

  task automatic test_small_corners();
    set_vertex_count(5'd0);
    send_beat(MODE_CMP, MAT_SECOND, 4'd15, 16'hFFFF);
    set_vertex_count(5'd1);
    send_beat(MODE_LOAD, MAT_FIRST, 4'd0, 16'h8001);
    send_compare();
    send_beat(MODE_LOAD, MAT_SECOND, 4'd0, 16'hFFFF);
    send_compare();
    set_vertex_count(5'd3);
    send_beat(MODE_LOAD, MAT_FIRST, 4'd0, 16'h0002);
    send_beat(MODE_LOAD, MAT_FIRST, 4'd1, 16'h0004);
    send_beat(MODE_LOAD, MAT_FIRST, 4'd2, 16'h0001);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd0, 16'hFFF9);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd1, 16'h0002);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd2, 16'h0004);
    send_compare();
    // empty row, two bits in a row, shared column
    send_beat(MODE_LOAD, MAT_FIRST, 4'd1, 16'h0000);
    send_compare();
    send_beat(MODE_LOAD, MAT_FIRST, 4'd1, 16'h0006);
    send_compare();
    send_beat(MODE_LOAD, MAT_FIRST, 4'd1, 16'h0002);
    send_compare();
    send_beat(MODE_LOAD, MAT_FIRST, 4'd15, 16'hFFFF);
    send_beat(MODE_LOAD, MAT_FIRST, 4'd1, 16'h0004);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd0, 16'h0004);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd1, 16'h0001);
    send_beat(MODE_LOAD, MAT_SECOND, 4'd2, 16'h0002);
    send_compare();
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int n;
    logic [VC_W-1:0] vc;
    phase = 0;
    while (accepted_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: vc = VC_W'($urandom_range(1, 8));
        6: vc = VC_RESET;
        7: vc = VC_W'($urandom_range(9, 15));
        8: vc = VC_W'($urandom_range(17, 31));
        default: vc = '0;
      endcase
      set_vertex_count(vc);
      n = (vc > MAX_V) ? MAX_V : int'(vc);
      idling_on = (phase % 3) != 2;
      phase_end = accepted_items + 120;
      while (accepted_items < phase_end) run_sequence(n, $urandom_range(0, 9));
      phase++;
    end
    idling_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_vertex_count(5'd5);
    hold_request = 300;
    repeat (10) run_sequence(5, $urandom_range(0, 7));
    repeat (5) send_compare();
  endtask

  task automatic check_verdict();
    verdict_t got;
    verdict_t want;
    got.iso = out_isomorphic;
    got.malformed = out_malformed;
    got.cycles_first = out_cycles_first;
    got.cycles_second = out_cycles_second;
    if (verdict_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result beat: iso %0d malformed %0d cycles %0d/%0d",
                 got.iso, got.malformed, got.cycles_first, got.cycles_second);
      return;
    end
    want = verdict_q.pop_front();
    if (got.iso !== want.iso || got.malformed !== want.malformed ||
        got.cycles_first !== want.cycles_first || got.cycles_second !== want.cycles_second) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected iso %0d malformed %0d cycles %0d/%0d, got %0d %0d %0d/%0d",
                 want.iso, want.malformed, want.cycles_first, want.cycles_second,
                 got.iso, got.malformed, got.cycles_first, got.cycles_second);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_matrix_select = MAT_FIRST;
    in_row_index = '0;
    in_row_bits = '0;
    vertex_limit = VC_RESET;
    for (int m = 0; m < 2; m++)
      for (int r = 0; r < MAX_V; r++) row_store[m][r] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_full_width();
    test_small_corners();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("permutation_cycle_type_compare test passed");
    end else begin
      $display("permutation_cycle_type_compare test failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idling_on ? $urandom_range(0, 5) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_verdict();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("permutation_cycle_type_compare test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
